@@ src/nlcn_pkg.sv @@
`default_nettype none

package nlcn_pkg;

	// Default size of the line buffer in bytes.
	localparam int LINE_CAPACITY_DEF = 128;

	// Characters that the sentence format relies on.
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_N    = 8'h4E;
	localparam logic [7:0] CH_P    = 8'h50;

	// Changing "GN" to "GP" alters the checksum by this amount.
	localparam logic [7:0] TALKER_FIX = CH_N ^ CH_P;

	// The star must have at least two characters after it.
	localparam int MIN_TAIL = 3;

	// Star, two hex digits, CR and LF close every stored sentence.
	localparam int TRAILER_LEN = 5;

	// A talker rewrite needs at least this many content bytes.
	localparam int TALKER_MIN_LEN = 6;

	// Result codes.
	localparam logic [2:0] STAT_TAKEN    = 3'd0;
	localparam logic [2:0] STAT_STORED   = 3'd1;
	localparam logic [2:0] STAT_NO_STAR  = 3'd2;
	localparam logic [2:0] STAT_BAD_HEX  = 3'd3;
	localparam logic [2:0] STAT_MISMATCH = 3'd4;
	localparam logic [2:0] STAT_READ     = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK,
		ST_COPY,
		ST_READ,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_LINE_END,
		KIND_READ
	} item_kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic scan;
		logic check;
		logic copy;
		logic read_load;
		logic out_load;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		item_kind_t kind;
		logic       scan_done;
		logic       pass;
		logic       copy_done;
	} dp_stat_t;

	// Expected talker text "GNGGA" at line positions one to five.
	function automatic logic [7:0] talker_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd1:    c = 8'h47;
			3'd2:    c = 8'h4E;
			3'd3:    c = 8'h47;
			3'd4:    c = 8'h47;
			3'd5:    c = 8'h41;
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	// Hex digit decode; bit 4 flags a character that is not a hex digit.
	function automatic logic [4:0] hex_val(input logic [7:0] h);
		logic [4:0] r;
		if (h >= 8'h30 && h <= 8'h39) begin
			r = {1'b0, 4'(h - 8'h30)};
		end else if (h >= 8'h41 && h <= 8'h46) begin
			r = {1'b0, 4'(h - 8'h37)};
		end else if (h >= 8'h61 && h <= 8'h66) begin
			r = {1'b0, 4'(h - 8'h57)};
		end else begin
			r = 5'b10000;
		end
		return r;
	endfunction

	// Upper-case hex character for one nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'h0, nib};
		end else begin
			c = 8'h37 + {4'h0, nib};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ src/nlcn_req_if.sv @@
`default_nettype none

interface nlcn_req_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] rx_byte;
	logic [7:0] read_index;

	modport source (output valid, output cmd, output rx_byte, output read_index, input ready);
	modport sink (input valid, input cmd, input rx_byte, input read_index, output ready);
endinterface

`default_nettype wire

@@ src/nlcn_rsp_if.sv @@
`default_nettype none

interface nlcn_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] stored_length;
	logic [7:0] read_data;
	logic [7:0] line_checksum;
	logic       talker_rewritten;

	modport source (
		output valid, output status, output stored_length, output read_data,
		output line_checksum, output talker_rewritten, input ready
	);
	modport sink (
		input valid, input status, input stored_length, input read_data,
		input line_checksum, input talker_rewritten, output ready
	);
endinterface

`default_nettype wire

@@ src/nmea_line_checksum_normalizer.sv @@
`default_nettype none

// Channel  Dir  Beat contents
// -------  ---  ----------------------------------------------------------------
// req      in   cmd, rx_byte, read_index
// rsp      out  status, stored_length, read_data, line_checksum, talker_rewritten
//
// A byte push or CR goes straight to the finish step, and a read passes the read step first.
// A line end is scanned and checked, and when it is stored it is also copied: the line
// buffer read port steps once a cycle, first over the held bytes to check the line, then
// over the text up to the star and the trailer to copy it.
// Reset empties the line and the stored sentence at once.
// A new beat is taken while an earlier result waits on rsp; a stalled rsp holds the block
// in its last step until the result register frees.

module nmea_line_checksum_normalizer #(
	parameter int LINE_CAPACITY = nlcn_pkg::LINE_CAPACITY_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	nlcn_req_if.sink   req,
	nlcn_rsp_if.source rsp
);
	import nlcn_pkg::*;

	ctl_cmd_t ctl;
	dp_stat_t st;

	nlcn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.ctl       (ctl),
		.st        (st)
	);

	nlcn_datapath #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_datapath (
		.clk                  (clk),
		.arst_n               (arst_n),
		.ctl                  (ctl),
		.st                   (st),
		.req_cmd              (req.cmd),
		.req_rx_byte          (req.rx_byte),
		.req_read_index       (req.read_index),
		.rsp_status           (rsp.status),
		.rsp_stored_length    (rsp.stored_length),
		.rsp_read_data        (rsp.read_data),
		.rsp_line_checksum    (rsp.line_checksum),
		.rsp_talker_rewritten (rsp.talker_rewritten)
	);

	// The block is never ready in the cycle after an accept.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("input accepted again in the cycle after an accept");

	// Read data only appears on read results.
	a_rdata_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != STAT_READ |-> rsp.read_data == 8'h00)
		else $error("read data on a result that is not a read");

	// No checksum is reported where no line was checked.
	a_csum_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == STAT_TAKEN || rsp.status == STAT_NO_STAR
		|| rsp.status == STAT_READ) |-> rsp.line_checksum == 8'h00)
		else $error("checksum reported on a result without a checked line");

	// A talker rewrite only happens on a stored line.
	a_rewrite_stored: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.talker_rewritten |-> rsp.status == STAT_STORED)
		else $error("talker rewrite flagged on a line that was not stored");

endmodule

`default_nettype wire

@@ src/nlcn_ram.sv @@
`default_nettype none

module nlcn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one read port with registered data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ src/nlcn_ctrl.sv @@
`default_nettype none

module nlcn_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      nlcn_pkg::ctl_cmd_t ctl,
	input  wire nlcn_pkg::dp_stat_t st
);
	import nlcn_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (st.kind)
						KIND_READ:     state_nxt = ST_READ;
						KIND_LINE_END: state_nxt = ST_SCAN;
						default:       state_nxt = ST_FINISH;
					endcase
				end
			end
			ST_SCAN: begin
				if (st.scan_done) begin
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_nxt = st.pass ? ST_COPY : ST_FINISH;
			end
			ST_COPY: begin
				if (st.copy_done) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_READ: begin
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (slot_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Commands for the datapath.
	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				ctl.accept = in_valid;
			end
			ST_SCAN:   ctl.scan = 1'b1;
			ST_CHECK:  ctl.check = 1'b1;
			ST_COPY:   ctl.copy = 1'b1;
			ST_READ:   ctl.read_load = 1'b1;
			ST_FINISH: ctl.out_load = slot_free;
			default:   ctl = '0;
		endcase
	end

	// State and output beat flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ src/nlcn_datapath.sv @@
`default_nettype none

module nlcn_datapath #(
	parameter int LINE_CAPACITY = nlcn_pkg::LINE_CAPACITY_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire nlcn_pkg::ctl_cmd_t ctl,
	output      nlcn_pkg::dp_stat_t st,
	input  wire logic               req_cmd,
	input  wire logic [7:0]         req_rx_byte,
	input  wire logic [7:0]         req_read_index,
	output      logic [2:0]         rsp_status,
	output      logic [7:0]         rsp_stored_length,
	output      logic [7:0]         rsp_read_data,
	output      logic [7:0]         rsp_line_checksum,
	output      logic               rsp_talker_rewritten
);
	import nlcn_pkg::*;

	localparam int LAW = $clog2(LINE_CAPACITY);
	localparam int SAW = $clog2(LINE_CAPACITY + 1);
	localparam int IW  = $clog2(LINE_CAPACITY + 2);

	// Line buffer fill and the shared scan and copy pointer.
	logic [LAW-1:0] fill_q;
	logic [IW-1:0]  idx_q;
	logic           rv_s1;
	logic [IW-1:0]  ridx_s1;

	// Scan findings.
	logic           zero_q;
	logic           found_q;
	logic [1:0]     after_q;
	logic [IW-1:0]  len_q;
	logic [IW-1:0]  star_q;
	logic [7:0]     acc_q;
	logic [7:0]     sxor_q;
	logic [7:0]     hi_q;
	logic [7:0]     lo_q;
	logic           match_q;

	// Copy settings and stored sentence length.
	logic           rw_q;
	logic [7:0]     cs2_q;
	logic [IW-1:0]  sent_len_q;
	logic           rd_ok_q;

	// Pending result.
	logic [2:0]     res_status_q;
	logic [7:0]     res_rdata_q;
	logic [7:0]     res_csum_q;
	logic           res_rw_q;

	// Output beat payload.
	logic [2:0]     out_status_q;
	logic [7:0]     out_len_q;
	logic [7:0]     out_rdata_q;
	logic [7:0]     out_csum_q;
	logic           out_rw_q;

	item_kind_t     kind;
	logic           line_we;
	logic           line_re;
	logic [7:0]     line_rd;
	logic           sent_we;
	logic           sent_re;
	logic [7:0]     sent_rd;
	logic [7:0]     sent_wdata;
	logic           scan_more;
	logic           scan_issue;
	logic [IW-1:0]  copy_end;
	logic           copy_more;
	logic           copy_issue;
	logic [2:0]     tail;
	logic           tail_ok;
	logic [4:0]     hv;
	logic [4:0]     lv;
	logic           bad_hex;
	logic           sum_ok;
	logic           rewrite;
	logic           rd_in_range;

	// Classify the incoming beat.
	always_comb begin
		if (req_cmd) begin
			kind = KIND_READ;
		end else if (req_rx_byte == CH_LF) begin
			kind = KIND_LINE_END;
		end else begin
			kind = KIND_BYTE;
		end
	end

	assign line_we = ctl.accept && kind == KIND_BYTE && req_rx_byte != CH_CR
		&& IW'(fill_q) < IW'(LINE_CAPACITY - 1);

	// Scan and copy both step the line buffer read port one byte a cycle.
	assign scan_more  = !zero_q && idx_q < IW'(fill_q);
	assign scan_issue = ctl.scan && scan_more;
	assign copy_end   = star_q + IW'(TRAILER_LEN);
	assign copy_more  = idx_q < copy_end;
	assign copy_issue = ctl.copy && copy_more;
	assign line_re    = scan_issue || copy_issue;

	nlcn_ram #(
		.WIDTH(8),
		.DEPTH(LINE_CAPACITY)
	) u_line_ram (
		.clk   (clk),
		.we    (line_we),
		.waddr (fill_q),
		.wdata (req_rx_byte),
		.re    (line_re),
		.raddr (LAW'(idx_q)),
		.rdata (line_rd)
	);

	// Stored sentence byte: copied text, then star, checksum and CR LF.
	assign tail = 3'(ridx_s1 - star_q);

	always_comb begin
		if (ridx_s1 < star_q) begin
			sent_wdata = (rw_q && ridx_s1 == IW'(2)) ? CH_P : line_rd;
		end else begin
			case (tail)
				3'd0:    sent_wdata = CH_STAR;
				3'd1:    sent_wdata = hex_char(cs2_q[7:4]);
				3'd2:    sent_wdata = hex_char(cs2_q[3:0]);
				3'd3:    sent_wdata = CH_CR;
				default: sent_wdata = CH_LF;
			endcase
		end
	end

	assign sent_we     = ctl.copy && rv_s1;
	assign sent_re     = ctl.accept && kind == KIND_READ;
	assign rd_in_range = 10'(req_read_index) < 10'(sent_len_q);

	nlcn_ram #(
		.WIDTH(8),
		.DEPTH(LINE_CAPACITY + 1)
	) u_sent_ram (
		.clk   (clk),
		.we    (sent_we),
		.waddr (SAW'(ridx_s1)),
		.wdata (sent_wdata),
		.re    (sent_re),
		.raddr (SAW'(req_read_index)),
		.rdata (sent_rd)
	);

	// Line verdict from the scan findings.
	assign hv      = hex_val(hi_q);
	assign lv      = hex_val(lo_q);
	assign tail_ok = found_q && after_q == 2'(MIN_TAIL - 1);
	assign bad_hex = hv[4] || lv[4];
	assign sum_ok  = {hv[3:0], lv[3:0]} == sxor_q;
	assign rewrite = match_q && len_q >= IW'(TALKER_MIN_LEN);

	assign st.kind      = kind;
	assign st.scan_done = !scan_more && !rv_s1;
	assign st.pass      = tail_ok && !bad_hex && sum_ok;
	assign st.copy_done = !copy_more && !rv_s1;

	// Control registers: fill level, read pipe flag and stored length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			rv_s1      <= 1'b0;
			sent_len_q <= '0;
		end else begin
			rv_s1 <= line_re;
			if (line_we) begin
				fill_q <= fill_q + LAW'(1);
			end else if (ctl.check) begin
				fill_q <= '0;
			end
			if (ctl.copy && !copy_more && !rv_s1) begin
				sent_len_q <= copy_end;
			end
		end
	end

	// Scan state, verdict and result registers.
	always_ff @(posedge clk) begin
		ridx_s1 <= idx_q;
		if (line_re) begin
			idx_q <= idx_q + IW'(1);
		end

		if (ctl.accept) begin
			idx_q   <= '0;
			zero_q  <= 1'b0;
			found_q <= 1'b0;
			after_q <= '0;
			len_q   <= '0;
			acc_q   <= '0;
			match_q <= 1'b1;
			rd_ok_q <= rd_in_range;
			if (kind == KIND_READ) begin
				res_status_q <= STAT_READ;
			end else begin
				res_status_q <= STAT_TAKEN;
			end
			res_rdata_q <= '0;
			res_csum_q  <= '0;
			res_rw_q    <= 1'b0;
		end

		// Each line byte as it comes back from the buffer.
		if (ctl.scan && rv_s1 && !zero_q) begin
			if (line_rd == CH_NUL) begin
				zero_q <= 1'b1;
			end else begin
				len_q <= ridx_s1 + IW'(1);
				if (ridx_s1 != '0) begin
					acc_q <= acc_q ^ line_rd;
				end
				if (line_rd == CH_STAR) begin
					star_q  <= ridx_s1;
					found_q <= 1'b1;
					sxor_q  <= acc_q;
					after_q <= '0;
				end else if (found_q && after_q != 2'(MIN_TAIL - 1)) begin
					if (after_q == 2'd0) begin
						hi_q <= line_rd;
					end else begin
						lo_q <= line_rd;
					end
					after_q <= after_q + 2'd1;
				end
				if (ridx_s1 >= IW'(1) && ridx_s1 <= IW'(5)
					&& line_rd != talker_char(3'(ridx_s1))) begin
					match_q <= 1'b0;
				end
			end
		end

		// Line verdict and the checksum of the rewritten sentence.
		if (ctl.check) begin
			idx_q <= '0;
			rw_q  <= rewrite;
			cs2_q <= sxor_q ^ ((rewrite && star_q > IW'(2)) ? TALKER_FIX : 8'h00);
			res_rdata_q <= '0;
			if (!tail_ok) begin
				res_status_q <= STAT_NO_STAR;
				res_csum_q   <= '0;
				res_rw_q     <= 1'b0;
			end else if (bad_hex) begin
				res_status_q <= STAT_BAD_HEX;
				res_csum_q   <= sxor_q;
				res_rw_q     <= 1'b0;
			end else if (!sum_ok) begin
				res_status_q <= STAT_MISMATCH;
				res_csum_q   <= sxor_q;
				res_rw_q     <= 1'b0;
			end else begin
				res_status_q <= STAT_STORED;
				res_csum_q   <= sxor_q;
				res_rw_q     <= rewrite;
			end
		end

		if (ctl.read_load) begin
			res_rdata_q <= rd_ok_q ? sent_rd : 8'h00;
		end

		// Output beat payload.
		if (ctl.out_load) begin
			out_status_q <= res_status_q;
			out_len_q    <= 8'(sent_len_q);
			out_rdata_q  <= res_rdata_q;
			out_csum_q   <= res_csum_q;
			out_rw_q     <= res_rw_q;
		end
	end

	assign rsp_status           = out_status_q;
	assign rsp_stored_length    = out_len_q;
	assign rsp_read_data        = out_rdata_q;
	assign rsp_line_checksum    = out_csum_q;
	assign rsp_talker_rewritten = out_rw_q;

endmodule

`default_nettype wire
